// ===== hdl/utf8v_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8v_pkg
// Constants shared by the UTF-8 string validator: widths, byte masks and
// code point limits of the strict policy.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;
  localparam int unsigned LenW  = 3;

  // item kinds
  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // byte classes
  localparam logic [ByteW-1:0] CtrlLimit  = 8'h20;
  localparam logic [ByteW-1:0] TabByte    = 8'h09;
  localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code  = 8'hF0;
  localparam logic [1:0]       ContTag    = 2'b10;

  // sequence lengths
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  // code point limits
  localparam logic [CpW-1:0] Min2     = 21'h00080;
  localparam logic [CpW-1:0] Min3     = 21'h00800;
  localparam logic [CpW-1:0] Min4     = 21'h10000;
  localparam logic [CpW-1:0] MaxCp    = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLow  = 21'h0D800;
  localparam logic [CpW-1:0] SurrHigh = 21'h0DFFF;

endpackage : utf8v_pkg
`default_nettype wire

// ===== hdl/utf8_string_validator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_string_validator_top
// Strict UTF-8 string checker. Bytes of a string arrive one per beat on the
// item channel; an end-of-string beat returns one verdict on the result
// channel.
//
// Item channel: item_valid / item_stall with kind and byte_value. kind = 0
// carries a string byte, kind = 1 marks the end of the string (byte_value is
// ignored). Result channel: result_valid / result_stall with string_valid,
// one beat per end-of-string item and nothing for data bytes.
// A beat is registered at the input, checked against the sequence state,
// and the verdict lands in the result register. Throughput is one byte per
// cycle while no end-of-string beat waits for the result slot, set by the
// state update of the decode stage.
// Reset (rst, synchronous) empties both registers and clears the sequence
// state and the sticky fail flag. While result_stall holds a verdict, data
// bytes keep flowing; an end-of-string beat waits in the input register and
// item_stall rises until the result slot frees.
// ----------------------------------------------------------------------------
module utf8_string_validator_top
  import utf8v_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire logic             kind,
  input  wire logic [ByteW-1:0] byte_value,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output logic                  string_valid
);

  // input register
  logic             s1_valid;
  logic             s1_kind;
  logic [ByteW-1:0] s1_byte;

  // sequence state
  logic [PendW-1:0] bytes_pending, bytes_pending_next;
  logic [LenW-1:0]  sequence_length, sequence_length_next;
  logic [CpW-1:0]   code_accumulator, code_accumulator_next;
  logic             failed, failed_next;

  logic           out_free;
  logic           s1_go;
  logic           item_take;
  logic [CpW-1:0] cp_shift;
  logic           cp_bad;

  assign out_free   = !result_valid || !result_stall;
  assign s1_go      = s1_valid && (s1_kind == KindData || out_free);
  assign item_stall = s1_valid && !s1_go;
  assign item_take  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_kind <= kind;
      s1_byte <= byte_value;
    end
  end

  assign cp_shift = {code_accumulator[CpW-7:0], s1_byte[5:0]};

  always_comb begin
    cp_bad = 1'b0;
    case (sequence_length)
      Len2:    cp_bad = cp_shift < Min2;
      Len3:    cp_bad = cp_shift < Min3;
      Len4:    cp_bad = (cp_shift < Min4) || (cp_shift > MaxCp);
      default: cp_bad = 1'b0;
    endcase
    if (cp_shift >= SurrLow && cp_shift <= SurrHigh) begin
      cp_bad = 1'b1;
    end
  end

  always_comb begin
    bytes_pending_next    = bytes_pending;
    sequence_length_next  = sequence_length;
    code_accumulator_next = code_accumulator;
    failed_next           = failed;
    if (s1_go) begin
      if (s1_kind == KindEnd) begin
        bytes_pending_next    = '0;
        sequence_length_next  = '0;
        code_accumulator_next = '0;
        failed_next           = 1'b0;
      end else if (!failed) begin
        if (bytes_pending == '0) begin
          if (!s1_byte[7]) begin
            if (s1_byte < CtrlLimit && s1_byte != TabByte) begin
              failed_next = 1'b1;
            end
          end else if ((s1_byte & Lead2Mask) == Lead2Code) begin
            sequence_length_next  = Len2;
            bytes_pending_next    = 2'd1;
            code_accumulator_next = CpW'(s1_byte[4:0]);
          end else if ((s1_byte & Lead3Mask) == Lead3Code) begin
            sequence_length_next  = Len3;
            bytes_pending_next    = 2'd2;
            code_accumulator_next = CpW'(s1_byte[3:0]);
          end else if ((s1_byte & Lead4Mask) == Lead4Code) begin
            sequence_length_next  = Len4;
            bytes_pending_next    = 2'd3;
            code_accumulator_next = CpW'(s1_byte[2:0]);
          end else begin
            failed_next = 1'b1;
          end
        end else if (s1_byte[7:6] != ContTag) begin
          failed_next = 1'b1;
        end else begin
          bytes_pending_next = bytes_pending - 2'd1;
          if (bytes_pending == 2'd1) begin
            // last continuation: judge the finished code point
            failed_next           = cp_bad;
            sequence_length_next  = '0;
            code_accumulator_next = '0;
          end else begin
            code_accumulator_next = cp_shift;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending    <= '0;
      sequence_length  <= '0;
      code_accumulator <= '0;
      failed           <= 1'b0;
    end else begin
      bytes_pending    <= bytes_pending_next;
      sequence_length  <= sequence_length_next;
      code_accumulator <= code_accumulator_next;
      failed           <= failed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_kind == KindEnd) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_kind == KindEnd) begin
      string_valid <= !failed && bytes_pending == '0;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid)
    else $error("item_stall raised with empty input register");

  a_idle_seq_clear: assert property (@(posedge clk) disable iff (rst)
    bytes_pending == '0 |-> sequence_length == '0 && code_accumulator == '0)
    else $error("sequence state left over with nothing pending");

  a_pending_fits_len: assert property (@(posedge clk) disable iff (rst)
    bytes_pending != '0 |-> sequence_length > LenW'(bytes_pending))
    else $error("pending count exceeds sequence length");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_kind == KindEnd |=> result_valid)
    else $error("end-of-string beat produced no result");

  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    !result_valid ##1 result_valid |-> $past(s1_go && s1_kind == KindEnd))
    else $error("result appeared without an end-of-string beat");
`endif

endmodule : utf8_string_validator_top
`default_nettype wire
